[rtl/vlos_pkg.sv]
// Shared types and constants of the voxel line-of-sight block.
package vlos_pkg;

  localparam int AXIS_BITS_DEF = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_STEP,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic clr;
    logic wr;
    logic load;
    logic setup;
    logic step;
    logic res_set;
    logic res_val;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic da_zero;
    logic hit;
    logic rem_zero;
  } sts_t;

endpackage

[rtl/vlos_ctrl.sv]
// Controller state machine of the voxel line-of-sight block.
module vlos_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  vlos_pkg::sts_t     sts_i,
  output vlos_pkg::cmd_t     cmd_o
);
  import vlos_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && op_i == OP_QUERY) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = sts_i.da_zero ? ST_FINISH : ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.hit || sts_i.rem_zero) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.wr   = in_valid_i && op_i == OP_WRITE;
        cmd_o.load = in_valid_i && op_i == OP_QUERY;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.da_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = 1'b1;
        end
      end
      ST_STEP: begin
        priority if (sts_i.hit) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = 1'b0;
        end else if (sts_i.rem_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_val = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i)       out_valid_d = 1'b0;
    else                         out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/vlos_dp.sv]
// Datapath of the voxel line-of-sight block: occupancy memory and line stepper.
module vlos_dp #(
  parameter int AXIS_BITS = vlos_pkg::AXIS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AXIS_BITS-1:0] start_x_i,
  input  logic [AXIS_BITS-1:0] start_y_i,
  input  logic [AXIS_BITS-1:0] start_z_i,
  input  logic [AXIS_BITS-1:0] end_x_i,
  input  logic [AXIS_BITS-1:0] end_y_i,
  input  logic [AXIS_BITS-1:0] end_z_i,
  input  logic                 occupied_i,
  output logic                 visible_o,
  input  vlos_pkg::cmd_t       cmd_i,
  output vlos_pkg::sts_t       sts_o
);
  import vlos_pkg::*;

  localparam int AW     = 3 * AXIS_BITS;
  localparam int VOXELS = 1 << AW;
  localparam int EW     = AXIS_BITS + 3;

  logic mem [VOXELS];

  logic [AW-1:0]        clr_q;
  logic [AW-1:0]        wa, ra;
  logic                 we, wd;
  logic                 rd_q;
  logic                 pend_q;

  logic [AXIS_BITS-1:0] cx_q, cy_q, cz_q;
  logic [AXIS_BITS-1:0] nx, ny, nz;
  logic                 sx_q, sy_q, sz_q;
  logic [AXIS_BITS-1:0] da_q, db_q, dm_q, rem_q;
  axis_e                axis_q;
  logic signed [EW-1:0] e1_q, e2_q, e1_d, e2_d;
  logic signed [EW-1:0] da1, da2, db2, dm2;
  logic                 res_q, vis_q;

  logic [AXIS_BITS-1:0] dx, dy, dz;
  logic                 gx, gy, gz;
  axis_e                axis_d;
  logic                 step_b, step_m, mv_x, mv_y, mv_z;

  assign gx = end_x_i > start_x_i;
  assign gy = end_y_i > start_y_i;
  assign gz = end_z_i > start_z_i;
  assign dx = gx ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign dy = gy ? end_y_i - start_y_i : start_y_i - end_y_i;
  assign dz = gz ? end_z_i - start_z_i : start_z_i - end_z_i;

  always_comb begin
    priority if (dx >= dy && dx >= dz) axis_d = AXIS_X;
    else if (dy >= dz)                 axis_d = AXIS_Y;
    else                               axis_d = AXIS_Z;
  end

  assign da1 = signed'({3'b000, da_q});
  assign da2 = signed'({2'b00, da_q, 1'b0});
  assign db2 = signed'({2'b00, db_q, 1'b0});
  assign dm2 = signed'({2'b00, dm_q, 1'b0});

  assign step_b = !e1_q[EW-1] && (e1_q != '0);
  assign step_m = !e2_q[EW-1] && (e2_q != '0);

  always_comb begin
    mv_x = 1'b0;
    mv_y = 1'b0;
    mv_z = 1'b0;
    unique case (axis_q)
      AXIS_X: begin
        mv_x = 1'b1;
        mv_y = step_b;
        mv_z = step_m;
      end
      AXIS_Y: begin
        mv_y = 1'b1;
        mv_x = step_b;
        mv_z = step_m;
      end
      AXIS_Z: begin
        mv_z = 1'b1;
        mv_x = step_b;
        mv_y = step_m;
      end
      default: begin
        mv_x = 1'b0;
      end
    endcase
  end

  assign nx = !mv_x ? cx_q : (sx_q ? cx_q + AXIS_BITS'(1) : cx_q - AXIS_BITS'(1));
  assign ny = !mv_y ? cy_q : (sy_q ? cy_q + AXIS_BITS'(1) : cy_q - AXIS_BITS'(1));
  assign nz = !mv_z ? cz_q : (sz_q ? cz_q + AXIS_BITS'(1) : cz_q - AXIS_BITS'(1));

  assign e1_d = e1_q - (step_b ? da2 : '0) + db2;
  assign e2_d = e2_q - (step_m ? da2 : '0) + dm2;

  assign we = cmd_i.clr || cmd_i.wr;
  assign wd = cmd_i.clr ? 1'b0 : occupied_i;
  assign wa = cmd_i.clr ? clr_q : {start_z_i, start_y_i, start_x_i};
  assign ra = {nz, ny, nx};

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + AW'(1);
      pend_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q   <= start_x_i;
      cy_q   <= start_y_i;
      cz_q   <= start_z_i;
      sx_q   <= gx;
      sy_q   <= gy;
      sz_q   <= gz;
      axis_q <= axis_d;
      unique case (axis_d)
        AXIS_X: begin
          da_q <= dx;
          db_q <= dy;
          dm_q <= dz;
        end
        AXIS_Y: begin
          da_q <= dy;
          db_q <= dx;
          dm_q <= dz;
        end
        default: begin
          da_q <= dz;
          db_q <= dx;
          dm_q <= dy;
        end
      endcase
    end
    if (cmd_i.setup) begin
      e1_q  <= db2 - da1;
      e2_q  <= dm2 - da1;
      rem_q <= da_q;
    end
    if (cmd_i.step) begin
      cx_q  <= nx;
      cy_q  <= ny;
      cz_q  <= nz;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      rem_q <= rem_q - AXIS_BITS'(1);
    end
    if (cmd_i.res_set)  res_q <= cmd_i.res_val;
    if (cmd_i.out_load) vis_q <= res_q;
  end

  assign visible_o      = vis_q;
  assign sts_o.clr_last = &clr_q;
  assign sts_o.da_zero  = da_q == '0;
  assign sts_o.hit      = pend_q && rd_q;
  assign sts_o.rem_zero = rem_q == '0;

endmodule

[rtl/voxel_line_of_sight.sv]
// Voxel line-of-sight block: occupancy bitmap with 3D line walk queries.
//
// Input channel (in_valid_i / in_stall_o) takes one word per item. A write
// word (op 0) stores occupied_i at the start coordinates and gives no
// result. A query word (op 1) walks the line from start to end and
// returns one visible_o word on the output channel (out_valid_o /
// out_stall_i): 0 at the first occupied voxel past the start, 1 otherwise.
// A query whose start equals end skips the walk; a blocked query ends early.
// The input is stalled until the cycle after the result is loaded.
// The walk is paced by the single memory read port: one voxel read per step.
// After reset the block clears all 2^(3*AXIS_BITS) voxels of the bitmap
// (32768 by default), one voxel a cycle, and stalls the input meanwhile.
// A waiting result is held in the output register while the receiver stalls;
// writes and the next query are still accepted, and a later query holds in
// its final state until the output register is free.
module voxel_line_of_sight #(
  parameter int AXIS_BITS = vlos_pkg::AXIS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [AXIS_BITS-1:0] start_x_i,
  input  logic [AXIS_BITS-1:0] start_y_i,
  input  logic [AXIS_BITS-1:0] start_z_i,
  input  logic [AXIS_BITS-1:0] end_x_i,
  input  logic [AXIS_BITS-1:0] end_y_i,
  input  logic [AXIS_BITS-1:0] end_z_i,
  input  logic                 occupied_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o
);
  import vlos_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vlos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vlos_dp #(
    .AXIS_BITS (AXIS_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .start_z_i  (start_z_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .end_z_i    (end_z_i),
    .occupied_i (occupied_i),
    .visible_o  (visible_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
